// ===== rtl/mssp_pkg.sv =====
// ----------------------------------------------------------------------------
// mssp_pkg: shared types and constants of the multi-slot sample player
// Command and register codes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package mssp_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int MAX_FRAMES_DEF = 65536;

    localparam int POS_W          = 33;          // Q17.16 slot position
    localparam int ENV_ONE        = 32768;       // 1.0 in Q1.15
    localparam int GAIN_MAX       = 32768;       // 2.0 in Q2.14
    localparam int GAIN_ONE       = 16384;       // 1.0 in Q2.14
    localparam int RATE_ONE       = 65536;       // 1.0 in Q16.16
    localparam int FADE_RESET     = 176;
    localparam int FADE_MAX       = 131071;
    localparam int ENV_STEP_RESET = 186;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [3:0] {
        CMD_TICK   = 4'd0,
        CMD_WRITE  = 4'd1,
        CMD_TRIG   = 4'd2,
        CMD_STOP   = 4'd3,
        CMD_LENGTH = 4'd4,
        CMD_RATE   = 4'd5,
        CMD_GAIN   = 4'd6,
        CMD_LOOP   = 4'd7,
        CMD_FADE   = 4'd8
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_GAIN = 2'd0,
        CFG_ENV_STEP    = 2'd1,
        CFG_CUE_ENABLE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_GAIN1,
        ST_GAIN2,
        ST_TAPS,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_MIX,
        ST_DONE
    } t_state;

    // Saturate a 32-bit signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/multi_slot_sample_player.sv =====
// ----------------------------------------------------------------------------
// multi_slot_sample_player: multi-slot one-shot/loop sample player
// Plays stereo samples from a single shared store, one region per slot, with Hermite interpolation,
// linear fades and gain, and mixes them onto the master bus and, when enabled, the cue bus.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Beat taken when
//  --------  -----------------------------------  -------------------------
//  command   i_valid / o_stall, i_cmd ... i_bus_*  i_valid & !o_stall
//  result    o_valid / i_stall, o_master_* ...     o_valid & !i_stall
//  config    i_cfg_valid / o_cfg_ready, index,data i_cfg_valid & o_cfg_ready
//
// Commands other than a tick give no result beat. A tick evaluates every
// slot in turn and skips those not playing; per playing slot the sequencer
// evaluates it, does two gain multiplies, reads four taps through the single
// read port of the sample store and runs the Hermite and mix steps.
// Reset returns slot state and control registers to their defaults; the
// datapath and output data registers and the sample store are not cleared.
// The command side stalls while a tick runs, and ST_DONE at the tick's end
// waits only while the previous result is held and i_stall is high.
//
module multi_slot_sample_player
    import mssp_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [3:0]            i_cmd,
    input  logic [2:0]            i_slot,
    input  logic [15:0]           i_frame_addr,
    input  logic [31:0]           i_value,
    input  logic signed [15:0]    i_sample_left,
    input  logic signed [15:0]    i_sample_right,
    input  logic signed [15:0]    i_bus_master_left,
    input  logic signed [15:0]    i_bus_master_right,
    input  logic signed [15:0]    i_bus_cue_left,
    input  logic signed [15:0]    i_bus_cue_right,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_master_left,
    output logic signed [15:0]    o_master_right,
    output logic signed [15:0]    o_cue_left,
    output logic signed [15:0]    o_cue_right,
    output logic [NUM_SLOTS-1:0]  o_playing_mask,
    // Configuration channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
    localparam int DEPTH   = NUM_SLOTS * MAX_FRAMES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int I1_W    = POS_W - 16;
    // Width for comparing positions against length and fade in Q.16 form.
    localparam int PW      = ((LEN_W + 16 > POS_W) ? LEN_W + 16 : POS_W) + 1;
    localparam int IDX_W   = ((I1_W > LEN_W) ? I1_W : LEN_W) + 2;
    localparam int T_W     = 44;   // Hermite accumulator
    localparam int MIX_W   = 24;   // sum of all slot contributions

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [15:0]            r_master;
    logic [15:0]            r_env_step;
    logic                   r_cue_en;

    logic [POS_W-1:0]       r_pos   [NUM_SLOTS];
    logic [15:0]            r_env   [NUM_SLOTS];
    logic [LEN_W-1:0]       r_len   [NUM_SLOTS];
    logic [31:0]            r_rate  [NUM_SLOTS];
    logic [15:0]            r_gain  [NUM_SLOTS];
    logic [16:0]            r_fade  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_playing;
    logic [NUM_SLOTS-1:0]   r_rel;
    logic [NUM_SLOTS-1:0]   r_loop;

    logic [SLOT_W-1:0]      r_k;
    logic [I1_W-1:0]        r_i1;
    logic [15:0]            r_frac;
    logic [15:0]            r_env_cur;
    logic [15:0]            r_g1;
    logic [16:0]            r_g;
    logic [2:0]             r_tcnt;
    logic                   r_tv;
    logic signed [15:0]     r_tap [2][4];
    logic signed [T_W-1:0]  r_t   [2];
    logic signed [16:0]     r_c2  [2];
    logic signed [15:0]     r_h   [2];
    logic signed [MIX_W-1:0] r_mix [2];
    logic signed [15:0]     r_bus_m [2];
    logic signed [15:0]     r_bus_c [2];

    logic                   r_out_valid;
    logic signed [15:0]     r_out_ml, r_out_mr, r_out_cl, r_out_cr;
    logic [NUM_SLOTS-1:0]   r_out_mask;

    // ------------------------------------------------------------------
    // Command decode. Slot state is read at one address: the command's
    // slot while idle, the sequencer's slot during a tick.
    // ------------------------------------------------------------------
    logic              in_beat;
    logic              slot_ok;
    logic [SLOT_W-1:0] sel;
    logic              out_free;

    assign in_beat  = i_valid && !o_stall;
    assign slot_ok  = 32'(i_slot) < NUM_SLOTS;
    assign sel      = (r_state == ST_IDLE) ? SLOT_W'(i_slot) : r_k;
    assign out_free = !r_out_valid || !i_stall;

    logic last_slot;
    assign last_slot = 32'(r_k) == NUM_SLOTS - 1;

    // ------------------------------------------------------------------
    // Slot evaluation: wrap or end, envelope ramp, next position.
    // ------------------------------------------------------------------
    logic [PW-1:0]    ev_len_q, ev_pos, ev_pos_w, ev_fade_q;
    logic [PW:0]      ev_sum;
    logic [POS_W-1:0] ev_pos_next;
    logic             ev_wrap, ev_fin_end, ev_near, ev_fin_env, ev_skip, ev_clear;
    logic [17:0]      ev_e, ev_st, ev_tg;
    logic [15:0]      ev_env;

    always_comb begin
        ev_len_q   = PW'({r_len[sel], 16'b0});
        ev_fade_q  = PW'({r_fade[sel], 16'b0});
        ev_pos     = PW'(r_pos[sel]);
        ev_wrap    = ev_pos >= ev_len_q;
        ev_fin_end = ev_wrap && !r_loop[sel];
        ev_pos_w   = ev_wrap ? ev_pos - ev_len_q : ev_pos;
        ev_near    = !r_loop[sel] && ((ev_len_q - ev_pos_w) < ev_fade_q);
        ev_tg      = (r_rel[sel] || ev_near) ? 18'd0 : 18'(ENV_ONE);
        ev_e       = 18'(r_env[sel]);
        ev_st      = 18'(r_env_step);
        if (ev_tg > ev_e) begin
            ev_env = (ev_e + ev_st > ev_tg) ? 16'(ev_tg) : 16'(ev_e + ev_st);
        end else begin
            ev_env = (ev_e < ev_tg + ev_st) ? 16'(ev_tg) : 16'(ev_e - ev_st);
        end
        ev_fin_env  = (ev_env == 16'd0) && (ev_tg == 18'd0);
        ev_clear    = r_playing[sel] && (r_len[sel] != '0) && (ev_fin_end || ev_fin_env);
        ev_skip     = (r_len[sel] == '0) || !r_playing[sel] || ev_fin_end || ev_fin_env;
        ev_sum      = (PW + 1)'(ev_pos_w) + (PW + 1)'(r_rate[sel]);
        ev_pos_next = (ev_sum > (PW + 1)'({POS_W{1'b1}})) ? {POS_W{1'b1}}
                                                          : POS_W'(ev_sum);
    end

    // ------------------------------------------------------------------
    // Tap addressing. Taps outside the sample read as zero.
    // ------------------------------------------------------------------
    logic signed [IDX_W-1:0] tap_idx;
    logic                    tap_ok;
    logic [ADDR_W-1:0]       tap_addr;

    always_comb begin
        tap_idx  = $signed({2'b00, r_i1}) - IDX_W'(1) + $signed(IDX_W'(r_tcnt));
        tap_ok   = !tap_idx[IDX_W-1] && (tap_idx[IDX_W-2:0] < (IDX_W - 1)'(r_len[r_k]));
        tap_addr = ADDR_W'(32'(r_k) * MAX_FRAMES + 32'(tap_idx[IDX_W-2:0]));
    end

    // ------------------------------------------------------------------
    // Gain, Hermite and mix arithmetic, both channels side by side.
    // ------------------------------------------------------------------
    logic [31:0]              gp1;
    logic [32:0]              gp2;
    logic signed [16:0]       frac_s;
    logic signed [16:0]       hc2 [2];
    logic signed [16:0]       hv  [2];
    logic signed [18:0]       hw2 [2];
    logic signed [21:0]       ha2 [2];
    logic signed [22:0]       hb2 [2];
    logic signed [39:0]       hp1 [2];
    logic signed [T_W+16:0]   hp2 [2];
    logic signed [T_W-1:0]    hrs [2];
    logic signed [31:0]       hy  [2];
    logic signed [33:0]       mp  [2];
    logic signed [33:0]       mc  [2];

    always_comb begin
        gp1    = {16'b0, r_env_cur} * {16'b0, r_gain[r_k]};
        gp2    = 33'(r_g1) * 33'(r_master);
        frac_s = $signed({1'b0, r_frac});
        for (int c = 0; c < 2; c++) begin
            hc2[c] = 17'(r_tap[c][2]) - 17'(r_tap[c][0]);
            hv[c]  = 17'(r_tap[c][1]) - 17'(r_tap[c][2]);
            hw2[c] = 19'(hc2[c]) + (19'(hv[c]) <<< 1);
            ha2[c] = 22'(hw2[c]) + (22'(hv[c]) <<< 1)
                     + 22'(r_tap[c][3]) - 22'(r_tap[c][1]);
            hb2[c] = 23'(hw2[c]) + 23'(ha2[c]);
            hp1[c] = 40'(ha2[c]) * 40'(frac_s);
            hp2[c] = (T_W + 17)'(r_t[c]) * (T_W + 17)'(frac_s);
            hrs[c] = r_t[c] + T_W'(65536);
            hy[c]  = 32'(r_tap[c][1]) + 32'(hrs[c] >>> 17);
            mp[c]  = 34'(r_h[c]) * $signed({17'b0, r_g});
            mc[c]  = (mp[c] + 34'sd8192) >>> 14;
        end
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && (t_cmd'(i_cmd) == CMD_TICK)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!ev_skip) begin
                    n_state = ST_GAIN1;
                end else if (last_slot) begin
                    n_state = ST_DONE;
                end
            end
            ST_GAIN1: n_state = ST_GAIN2;
            ST_GAIN2: n_state = ST_TAPS;
            ST_TAPS: begin
                if (r_tcnt == 3'd4) begin
                    n_state = ST_H1;
                end
            end
            ST_H1: n_state = ST_H2;
            ST_H2: n_state = ST_H3;
            ST_H3: n_state = ST_H4;
            ST_H4: n_state = ST_MIX;
            ST_MIX: n_state = last_slot ? ST_DONE : ST_EVAL;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and sample store ports.
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    always_comb begin
        o_stall     = r_state != ST_IDLE;
        o_cfg_ready = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(32'(sel) * MAX_FRAMES + 32'(i_frame_addr));
        ram_wdata   = {i_sample_right, i_sample_left};
        ram_raddr   = tap_addr;
        unique case (r_state)
            ST_IDLE: begin
                ram_we = in_beat && (t_cmd'(i_cmd) == CMD_WRITE) && slot_ok
                         && (32'(i_frame_addr) < MAX_FRAMES);
            end
            default: ram_we = 1'b0;
        endcase
    end

    mssp_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_master_left  = r_out_ml;
    assign o_master_right = r_out_mr;
    assign o_cue_left     = r_out_cl;
    assign o_cue_right    = r_out_cr;
    assign o_playing_mask = r_out_mask;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_master    <= 16'(GAIN_ONE);
            r_env_step  <= 16'(ENV_STEP_RESET);
            r_cue_en    <= 1'b0;
            r_playing   <= '0;
            r_rel       <= '0;
            r_loop      <= '0;
            r_k         <= '0;
            r_tcnt      <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_pos[s]  <= '0;
                r_env[s]  <= '0;
                r_len[s]  <= '0;
                r_rate[s] <= 32'(RATE_ONE);
                r_gain[s] <= 16'(GAIN_ONE);
                r_fade[s] <= 17'(FADE_RESET);
            end
        end else begin
            r_state <= n_state;

            // A new result loads the output register; otherwise a taken
            // beat empties it.
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes must arrive only while idle; the block does not enforce it.
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MASTER_GAIN: begin
                        r_master <= (i_cfg_data > 16'(GAIN_MAX)) ? 16'(GAIN_MAX)
                                                                 : i_cfg_data;
                    end
                    CFG_ENV_STEP:   r_env_step <= i_cfg_data;
                    CFG_CUE_ENABLE: r_cue_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_beat && (t_cmd'(i_cmd) == CMD_TICK)) begin
                        r_k        <= '0;
                        r_mix[0]   <= '0;
                        r_mix[1]   <= '0;
                        r_bus_m[0] <= i_bus_master_left;
                        r_bus_m[1] <= i_bus_master_right;
                        r_bus_c[0] <= i_bus_cue_left;
                        r_bus_c[1] <= i_bus_cue_right;
                    end else if (in_beat && slot_ok) begin
                        case (t_cmd'(i_cmd))
                            CMD_TRIG: begin
                                if (r_len[sel] != '0) begin
                                    r_pos[sel]     <= '0;
                                    r_rel[sel]     <= 1'b0;
                                    r_playing[sel] <= 1'b1;
                                end
                            end
                            CMD_STOP: begin
                                if (r_playing[sel]) begin
                                    r_rel[sel] <= 1'b1;
                                end
                            end
                            CMD_LENGTH: begin
                                r_len[sel] <= (i_value > 32'(MAX_FRAMES))
                                              ? LEN_W'(MAX_FRAMES) : LEN_W'(i_value);
                            end
                            CMD_RATE: r_rate[sel] <= i_value;
                            CMD_GAIN: begin
                                r_gain[sel] <= (i_value > 32'(GAIN_MAX))
                                               ? 16'(GAIN_MAX) : i_value[15:0];
                            end
                            CMD_LOOP: r_loop[sel] <= i_value[0];
                            CMD_FADE: begin
                                r_fade[sel] <= (i_value > 32'(FADE_MAX))
                                               ? 17'(FADE_MAX) : i_value[16:0];
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EVAL: begin
                    if (r_len[sel] == '0) begin
                        r_playing[sel] <= 1'b0;
                    end else if (!ev_skip) begin
                        r_env[sel] <= ev_env;
                    end
                    if (ev_clear) begin
                        r_pos[sel]     <= '0;
                        r_env[sel]     <= '0;
                        r_rel[sel]     <= 1'b0;
                        r_playing[sel] <= 1'b0;
                    end
                    if (!ev_skip) begin
                        r_pos[sel] <= ev_pos_next;
                        r_i1       <= ev_pos_w[POS_W-1:16];
                        r_frac     <= ev_pos_w[15:0];
                        r_env_cur  <= ev_env;
                    end else if (!last_slot) begin
                        r_k <= r_k + SLOT_W'(1);
                    end
                end
                ST_GAIN1: r_g1 <= gp1[30:15];
                ST_GAIN2: begin
                    r_g    <= gp2[30:14];
                    r_tcnt <= '0;
                end
                ST_TAPS: begin
                    r_tcnt <= r_tcnt + 3'd1;
                    r_tv   <= tap_ok;
                    if (r_tcnt != 3'd0) begin
                        r_tap[0][2'(r_tcnt - 3'd1)] <= r_tv ? $signed(ram_rdata[15:0])
                                                            : 16'sd0;
                        r_tap[1][2'(r_tcnt - 3'd1)] <= r_tv ? $signed(ram_rdata[31:16])
                                                            : 16'sd0;
                    end
                end
                ST_H1: begin
                    for (int c = 0; c < 2; c++) begin
                        r_t[c]  <= T_W'(hp1[c]) - (T_W'(hb2[c]) <<< 16);
                        r_c2[c] <= hc2[c];
                    end
                end
                ST_H2: begin
                    for (int c = 0; c < 2; c++) begin
                        r_t[c] <= T_W'(hp2[c] >>> 16) + (T_W'(r_c2[c]) <<< 16);
                    end
                end
                ST_H3: begin
                    for (int c = 0; c < 2; c++) begin
                        r_t[c] <= T_W'(hp2[c] >>> 16);
                    end
                end
                ST_H4: begin
                    for (int c = 0; c < 2; c++) begin
                        r_h[c] <= sat16(hy[c]);
                    end
                end
                ST_MIX: begin
                    for (int c = 0; c < 2; c++) begin
                        r_mix[c] <= r_mix[c] + MIX_W'(mc[c]);
                    end
                    if (!last_slot) begin
                        r_k <= r_k + SLOT_W'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_ml    <= sat16(32'(r_bus_m[0]) + 32'(r_mix[0]));
                        r_out_mr    <= sat16(32'(r_bus_m[1]) + 32'(r_mix[1]));
                        r_out_cl    <= r_cue_en ? sat16(32'(r_bus_c[0]) + 32'(r_mix[0]))
                                                : r_bus_c[0];
                        r_out_cr    <= r_cue_en ? sat16(32'(r_bus_c[1]) + 32'(r_mix[1]))
                                                : r_bus_c[1];
                        r_out_mask  <= r_playing;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0] len_nz;
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            len_nz[s] = r_len[s] != '0;
        end
    end

    // At the end of a tick no slot without a sample length is playing.
    a_no_play_unloaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ((r_playing & ~len_nz) == '0))
        else $error("slot without length still playing after tick");

    // The envelope never ramps past unity.
    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAIN1) |-> (r_env_cur <= 16'(ENV_ONE)))
        else $error("envelope above unity");

    // An accepted tick starts the slot sweep in the next cycle.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (t_cmd'(i_cmd) == CMD_TICK)) |=> (r_state == ST_EVAL && r_k == '0))
        else $error("tick did not start slot sweep");

    // The tap counter stays within the four taps plus the last capture.
    a_tap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAPS) |-> (r_tcnt <= 3'd4))
        else $error("tap counter out of range");

endmodule

// ===== rtl/mssp_ram.sv =====
// ----------------------------------------------------------------------------
// mssp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
